>>> hdl/ati_pkg.sv
package ati_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W = 7;

    // Fixed-point datapath widths
    localparam int FRAC_BITS = 24;
    localparam int DIFF_W = 33;
    localparam int QUO_W = DIFF_W + FRAC_BITS;
    localparam int ACC_W = 66;
    localparam int TERM_W = 41;

    // Request opcodes
    localparam logic [1:0] OP_LOAD_WIND = 2'd0;
    localparam logic [1:0] OP_LOAD_ATMOS = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_ZERO_SEG = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WIND_ENTRIES = 1'b0;
    localparam logic CFG_ATMOS_ENTRIES = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         index;
        logic signed [31:0] altitude;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
    } req_t;

    typedef struct packed {
        logic signed [31:0] zonal_wind;
        logic signed [31:0] meridional_wind;
        logic signed [31:0] pressure;
        logic signed [31:0] density;
        logic signed [31:0] temperature;
        logic signed [31:0] viscosity;
        logic [1:0]         status;
    } rsp_t;

    // Operands handed to one interpolation cell
    typedef struct packed {
        logic [QUO_W-1:0]   r_mag;
        logic               r_neg;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } mul_cmd_t;

endpackage

>>> hdl/altitude_table_interpolator.sv
// Channel   | Direction | Handshake              | Payload
// request   | in        | req_valid / req_ready  | req (req_t)
// response  | out       | rsp_valid / rsp_ready  | rsp (rsp_t)
// config    | in        | wr_en                  | wr_index, wr_data
// A load or a short-table query goes from acceptance straight to completion; a full query
// runs a key scan, a segment fetch, the serial dividers and the serial multipliers, then
// completes and returns to idle. A zero-width segment skips the dividers and multipliers.
// One request is in work at a time; the next is taken while a response waits.
// Reset clears the control state and both entry counts; tables are not cleared.
// A stalled response holds in the output register and blocks only completion.
module altitude_table_interpolator
    import ati_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [CFG_W-1:0] wr_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FETCH_HI = 3'd2;
    localparam logic [2:0] S_FETCH_LO = 3'd3;
    localparam logic [2:0] S_DIFF = 3'd4;
    localparam logic [2:0] S_DIVIDE = 3'd5;
    localparam logic [2:0] S_MULTIPLY = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    // Table memories
    logic signed [31:0] w_key_mem [TABLE_DEPTH];
    logic signed [31:0] w_zon_mem [TABLE_DEPTH];
    logic signed [31:0] w_mer_mem [TABLE_DEPTH];
    logic signed [31:0] a_key_mem [TABLE_DEPTH];
    logic signed [31:0] a_pre_mem [TABLE_DEPTH];
    logic signed [31:0] a_den_mem [TABLE_DEPTH];
    logic signed [31:0] a_tmp_mem [TABLE_DEPTH];
    logic signed [31:0] a_vis_mem [TABLE_DEPTH];
    logic signed [31:0] w_key_q, w_zon_q, w_mer_q;
    logic signed [31:0] a_key_q, a_pre_q, a_den_q, a_tmp_q, a_vis_q;
    logic [IDX_W-1:0]   w_addr, a_addr;

    logic [2:0]         state_reg;
    logic [CFG_W-1:0]   wind_entries_reg, atmos_entries_reg;
    logic signed [31:0] alt_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_v_reg;
    logic               w_found_reg, a_found_reg;
    logic [IDX_W-1:0]   w_up_reg, a_up_reg;
    logic signed [31:0] w_key_hi_reg, w_zon_hi_reg, w_mer_hi_reg;
    logic signed [31:0] a_key_hi_reg, a_pre_hi_reg, a_den_hi_reg, a_tmp_hi_reg, a_vis_hi_reg;
    logic signed [31:0] w_zon_lo_reg, w_mer_lo_reg;
    logic signed [31:0] a_pre_lo_reg, a_den_lo_reg, a_tmp_lo_reg, a_vis_lo_reg;
    logic               w_rneg_reg, a_rneg_reg;
    logic [1:0]         status_reg;
    logic               use_cells_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic [CNT_W-1:0]   nw, na;
    logic               w_hit, a_hit;
    logic [IDX_W-1:0]   w_sel, a_sel;
    logic               scan_end;
    logic               accept, rsp_free;
    logic signed [DIFF_W-1:0] w_dx, w_dh, a_dx, a_dh;
    logic [DIFF_W-1:0]  w_dx_mag, w_dh_mag, a_dx_mag, a_dh_mag;
    logic               div_start, mul_start;
    logic [QUO_W-1:0]   w_quot, a_quot;
    logic               w_div_done, a_div_done;
    mul_cmd_t           mul_cmd [6];
    logic signed [31:0] mul_res [6];
    logic [5:0]         mul_done;
    rsp_t               rsp_next;

    assign accept = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    // Entry counts limited to the table depth
    assign nw = (int'(wind_entries_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(wind_entries_reg);
    assign na = (int'(atmos_entries_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(atmos_entries_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wind_entries_reg  <= '0;
            atmos_entries_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_WIND_ENTRIES:  wind_entries_reg <= wr_data;
                CFG_ATMOS_ENTRIES: atmos_entries_reg <= wr_data;
                default:           wind_entries_reg <= wind_entries_reg;
            endcase
        end
    end

    // Read address for each table follows the phase of the query
    always_comb
    begin
        case (state_reg)
            S_SCAN:
            begin
                w_addr = scan_reg[IDX_W-1:0];
                a_addr = scan_reg[IDX_W-1:0];
            end
            S_FETCH_HI:
            begin
                w_addr = w_up_reg;
                a_addr = a_up_reg;
            end
            default:
            begin
                w_addr = w_up_reg - IDX_W'(1);
                a_addr = a_up_reg - IDX_W'(1);
            end
        endcase
    end

    // Memory writes on a load request, registered reads every cycle
    always_ff @(posedge clk)
    begin
        if (accept && req.opcode == OP_LOAD_WIND)
        begin
            w_key_mem[IDX_W'(req.index)] <= req.altitude;
            w_zon_mem[IDX_W'(req.index)] <= req.value_a;
            w_mer_mem[IDX_W'(req.index)] <= req.value_b;
        end
        if (accept && req.opcode == OP_LOAD_ATMOS)
        begin
            a_key_mem[IDX_W'(req.index)] <= req.altitude;
            a_pre_mem[IDX_W'(req.index)] <= req.value_a;
            a_den_mem[IDX_W'(req.index)] <= req.value_b;
            a_tmp_mem[IDX_W'(req.index)] <= req.value_c;
            a_vis_mem[IDX_W'(req.index)] <= req.value_d;
        end
        w_key_q <= w_key_mem[w_addr];
        w_zon_q <= w_zon_mem[w_addr];
        w_mer_q <= w_mer_mem[w_addr];
        a_key_q <= a_key_mem[a_addr];
        a_pre_q <= a_pre_mem[a_addr];
        a_den_q <= a_den_mem[a_addr];
        a_tmp_q <= a_tmp_mem[a_addr];
        a_vis_q <= a_vis_mem[a_addr];
    end

    // Search: first key above the altitude, then clamp to 1..count-1
    assign w_hit = cmp_v_reg && !w_found_reg && (CNT_W'(cmp_idx_reg) < nw)
                   && (w_key_q > alt_reg);
    assign a_hit = cmp_v_reg && !a_found_reg && (CNT_W'(cmp_idx_reg) < na)
                   && (a_key_q > alt_reg);
    assign w_sel = w_found_reg ? w_up_reg : (w_hit ? cmp_idx_reg : IDX_W'(nw - CNT_W'(1)));
    assign a_sel = a_found_reg ? a_up_reg : (a_hit ? cmp_idx_reg : IDX_W'(na - CNT_W'(1)));
    assign scan_end = cmp_v_reg && (cmp_idx_reg == IDX_W'(TABLE_DEPTH - 1));

    // Segment differences
    assign w_dx = DIFF_W'(alt_reg) - DIFF_W'(w_key_q);
    assign w_dh = DIFF_W'(w_key_hi_reg) - DIFF_W'(w_key_q);
    assign a_dx = DIFF_W'(alt_reg) - DIFF_W'(a_key_q);
    assign a_dh = DIFF_W'(a_key_hi_reg) - DIFF_W'(a_key_q);
    assign w_dx_mag = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
    assign w_dh_mag = w_dh[DIFF_W-1] ? DIFF_W'(-w_dh) : DIFF_W'(w_dh);
    assign a_dx_mag = a_dx[DIFF_W-1] ? DIFF_W'(-a_dx) : DIFF_W'(a_dx);
    assign a_dh_mag = a_dh[DIFF_W-1] ? DIFF_W'(-a_dh) : DIFF_W'(a_dh);

    assign div_start = (state_reg == S_DIFF) && (w_dh != '0) && (a_dh != '0);
    assign mul_start = (state_reg == S_DIVIDE) && w_div_done;

    // Control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            cmp_v_reg     <= 1'b0;
            w_found_reg   <= 1'b0;
            a_found_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            use_cells_reg <= 1'b0;
        end
        else
        begin
            // The completion state raises the response itself.
            if (rsp_valid_reg && rsp_ready && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        use_cells_reg <= 1'b0;
                        scan_reg      <= '0;
                        cmp_v_reg     <= 1'b0;
                        w_found_reg   <= 1'b0;
                        a_found_reg   <= 1'b0;
                        if (req.opcode == OP_QUERY && nw >= CNT_W'(2) && na >= CNT_W'(2))
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    scan_reg  <= scan_reg + CNT_W'(1);
                    cmp_v_reg <= (int'(scan_reg) < TABLE_DEPTH);
                    if (w_hit)
                    begin
                        w_found_reg <= 1'b1;
                    end
                    if (a_hit)
                    begin
                        a_found_reg <= 1'b1;
                    end
                    if (scan_end)
                    begin
                        state_reg <= S_FETCH_HI;
                    end
                end
                S_FETCH_HI:
                begin
                    state_reg <= S_FETCH_LO;
                end
                S_FETCH_LO:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    state_reg <= div_start ? S_DIVIDE : S_DONE;
                end
                S_DIVIDE:
                begin
                    if (w_div_done)
                    begin
                        state_reg <= S_MULTIPLY;
                    end
                end
                S_MULTIPLY:
                begin
                    if (mul_done[0])
                    begin
                        use_cells_reg <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                end
                default:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Datapath registers of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                alt_reg <= req.altitude;
                if (req.opcode == OP_QUERY && (nw < CNT_W'(2) || na < CNT_W'(2)))
                begin
                    status_reg <= ST_SHORT;
                end
                else
                begin
                    status_reg <= ST_OK;
                end
            end
            S_SCAN:
            begin
                cmp_idx_reg <= scan_reg[IDX_W-1:0];
                if (w_hit)
                begin
                    w_up_reg <= cmp_idx_reg;
                end
                if (a_hit)
                begin
                    a_up_reg <= cmp_idx_reg;
                end
                if (scan_end)
                begin
                    w_up_reg <= (w_sel == '0) ? IDX_W'(1) : w_sel;
                    a_up_reg <= (a_sel == '0) ? IDX_W'(1) : a_sel;
                end
            end
            S_FETCH_LO:
            begin
                w_key_hi_reg <= w_key_q;
                w_zon_hi_reg <= w_zon_q;
                w_mer_hi_reg <= w_mer_q;
                a_key_hi_reg <= a_key_q;
                a_pre_hi_reg <= a_pre_q;
                a_den_hi_reg <= a_den_q;
                a_tmp_hi_reg <= a_tmp_q;
                a_vis_hi_reg <= a_vis_q;
            end
            S_DIFF:
            begin
                w_zon_lo_reg <= w_zon_q;
                w_mer_lo_reg <= w_mer_q;
                a_pre_lo_reg <= a_pre_q;
                a_den_lo_reg <= a_den_q;
                a_tmp_lo_reg <= a_tmp_q;
                a_vis_lo_reg <= a_vis_q;
                w_rneg_reg   <= w_dx[DIFF_W-1] ^ w_dh[DIFF_W-1];
                a_rneg_reg   <= a_dx[DIFF_W-1] ^ a_dh[DIFF_W-1];
                if (!div_start)
                begin
                    status_reg <= ST_ZERO_SEG;
                end
            end
            default:
            begin
                alt_reg <= alt_reg;
            end
        endcase
    end

    // Segment ratio, one divider for each table
    ati_div_cell u_w_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (w_dx_mag),
        .den   (w_dh_mag),
        .quot  (w_quot),
        .done  (w_div_done)
    );

    ati_div_cell u_a_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (a_dx_mag),
        .den   (a_dh_mag),
        .quot  (a_quot),
        .done  (a_div_done)
    );

    // Operands for the row of interpolation cells
    assign mul_cmd[0] = '{r_mag: w_quot, r_neg: w_rneg_reg, lo: w_zon_lo_reg, hi: w_zon_hi_reg};
    assign mul_cmd[1] = '{r_mag: w_quot, r_neg: w_rneg_reg, lo: w_mer_lo_reg, hi: w_mer_hi_reg};
    assign mul_cmd[2] = '{r_mag: a_quot, r_neg: a_rneg_reg, lo: a_pre_lo_reg, hi: a_pre_hi_reg};
    assign mul_cmd[3] = '{r_mag: a_quot, r_neg: a_rneg_reg, lo: a_den_lo_reg, hi: a_den_hi_reg};
    assign mul_cmd[4] = '{r_mag: a_quot, r_neg: a_rneg_reg, lo: a_tmp_lo_reg, hi: a_tmp_hi_reg};
    assign mul_cmd[5] = '{r_mag: a_quot, r_neg: a_rneg_reg, lo: a_vis_lo_reg, hi: a_vis_hi_reg};

    for (genvar g = 0; g < 6; g++)
    begin : g_mul
        ati_mul_cell u_mul (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (mul_start),
            .cmd    (mul_cmd[g]),
            .result (mul_res[g]),
            .done   (mul_done[g])
        );
    end

    // Response assembly and output register
    always_comb
    begin
        rsp_next = '0;
        rsp_next.status = status_reg;
        if (use_cells_reg)
        begin
            rsp_next.zonal_wind      = mul_res[0];
            rsp_next.meridional_wind = mul_res[1];
            rsp_next.pressure        = mul_res[2];
            rsp_next.density         = mul_res[3];
            rsp_next.temperature     = mul_res[4];
            rsp_next.viscosity       = mul_res[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && rsp_free)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

`ifndef NO_ASSERTIONS
    // Both dividers run in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        w_div_done == a_div_done)
        else $error("divider cells out of step");

    // All interpolation cells finish together.
    a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MULTIPLY && mul_done[0]) |-> (mul_done == 6'h3f))
        else $error("interpolation cells out of step");

    // A new response is only raised when leaving the completion state.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("response raised outside completion");
`endif

endmodule

>>> hdl/ati_div_cell.sv
module ati_div_cell
    import ati_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIFF_W-1:0] num,
    input  logic [DIFF_W-1:0] den,
    output logic [QUO_W-1:0]  quot,
    output logic              done
);

    logic [DIFF_W-1:0] den_reg;
    logic [QUO_W-1:0]  num_reg;
    logic [DIFF_W-1:0] rem_reg;
    logic [QUO_W-1:0]  quot_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIFF_W:0]   trial;
    logic              fits;

    // One quotient bit per cycle, restoring form
    assign trial = {rem_reg, num_reg[QUO_W-1]};
    assign fits = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(QUO_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            num_reg  <= {num, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[QUO_W-2:0], 1'b0};
            if (fits)
            begin
                rem_reg  <= DIFF_W'(trial - {1'b0, den_reg});
                quot_reg <= {quot_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[DIFF_W-1:0];
                quot_reg <= {quot_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

>>> hdl/ati_mul_cell.sv
module ati_mul_cell
    import ati_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mul_cmd_t           cmd,
    output logic signed [31:0] result,
    output logic               done
);

    localparam logic [ACC_W-1:0] ACC_CAP = ACC_W'(1) << (ACC_W - 1);
    localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << (TERM_W - 1);

    logic [QUO_W-1:0]   r_reg;
    logic [DIFF_W-1:0]  d_reg;
    logic               sub_reg;
    logic signed [31:0] lo_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [5:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [31:0] result_reg;
    logic signed [DIFF_W-1:0] dy;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_next;
    logic [ACC_W-FRAC_BITS-1:0] term_full;
    logic [TERM_W-1:0]  term;
    logic signed [TERM_W+1:0] sum;
    logic signed [31:0] result_next;

    assign dy = DIFF_W'(cmd.hi) - DIFF_W'(cmd.lo);

    // Shift-add over the bits of |dy|, most significant first; the
    // accumulator saturates once the term is certain to hit its cap.
    assign acc_sum = {acc_reg, 1'b0} + (d_reg[DIFF_W-1] ? (ACC_W+1)'(r_reg) : '0);
    assign acc_next = (acc_sum >= (ACC_W+1)'(ACC_CAP)) ? ACC_CAP : acc_sum[ACC_W-1:0];

    // Final term, cap, signed add and saturation to 32 bits
    assign term_full = acc_reg[ACC_W-1:FRAC_BITS];
    assign term = (term_full > (ACC_W-FRAC_BITS)'(TERM_CAP)) ? TERM_CAP
                                                             : term_full[TERM_W-1:0];
    assign sum = sub_reg ? ((TERM_W+2)'(lo_reg) - $signed({2'b00, term}))
                         : ((TERM_W+2)'(lo_reg) + $signed({2'b00, term}));

    always_comb
    begin
        if (sum > (TERM_W+2)'(32'sh7fffffff))
        begin
            result_next = 32'sh7fffffff;
        end
        else if (sum < -(TERM_W+2)'(33'sh080000000))
        begin
            result_next = 32'sh80000000;
        end
        else
        begin
            result_next = sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(DIFF_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= cmd.r_mag;
            d_reg   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            sub_reg <= cmd.r_neg ^ dy[DIFF_W-1];
            lo_reg  <= cmd.lo;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                result_reg <= result_next;
            end
            else
            begin
                acc_reg <= acc_next;
                d_reg   <= {d_reg[DIFF_W-2:0], 1'b0};
            end
        end
    end

    assign result = result_reg;
    assign done = done_reg;

endmodule

>>> test/tb_altitude_table_interpolator.sv
`timescale 1ns / 1ps

import ati_pkg::*;

// Keeps the outstanding expected responses and counts mismatches.
class rsp_scoreboard;
    rsp_t pending[$];
    int   mismatches;

    function void note_request(rsp_t expected_rsp);
        pending.push_back(expected_rsp);
    endfunction

    function void check_response(rsp_t actual);
        rsp_t exp_rsp;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected response %h", actual);
            return;
        end
        exp_rsp = pending.pop_front();
        if (actual !== exp_rsp)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"Mismatch: expected zw=%0d mw=%0d p=%0d d=%0d t=%0d v=%0d st=%0d,",
                          " got zw=%0d mw=%0d p=%0d d=%0d t=%0d v=%0d st=%0d"},
                    exp_rsp.zonal_wind, exp_rsp.meridional_wind, exp_rsp.pressure,
                    exp_rsp.density, exp_rsp.temperature, exp_rsp.viscosity,
                    exp_rsp.status, actual.zonal_wind, actual.meridional_wind,
                    actual.pressure, actual.density, actual.temperature,
                    actual.viscosity, actual.status);
        end
    endfunction
endclass

module tb_altitude_table_interpolator;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    logic wr_en = 1'b0;
    logic wr_index = 1'b0;
    logic [CFG_W-1:0] wr_data = '0;

    altitude_table_interpolator dut (.*);

    always #5 clk = ~clk;

    // Model of the block's tables and counts
    logic signed [31:0] wind_key[TABLE_DEPTH];
    logic signed [31:0] wind_val[2][TABLE_DEPTH];
    logic signed [31:0] atm_key[TABLE_DEPTH];
    logic signed [31:0] atm_val[4][TABLE_DEPTH];
    int wind_count_reg;
    int atm_count_reg;

    rsp_scoreboard sb = new();
    int send_idle_pct;
    int stall_pct;

    function automatic int upper_index(input logic signed [31:0] keys[TABLE_DEPTH],
                                       input int n, input logic signed [31:0] alt);
        int i;
        i = 0;
        while (i < n && keys[i] <= alt)
            i++;
        if (i >= n)
            i = n - 1;
        if (i < 1)
            i = 1;
        return i;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // Applies the segment ratio to one value pair, with term cap and saturation.
    function automatic logic signed [31:0] blend(input bit rneg, input logic [63:0] rmag,
                                                 input longint lo, input longint hi);
        longint dy;
        logic [63:0] d, rh, rl, t, cap;
        longint r;
        dy = hi - lo;
        d = magnitude(dy);
        rh = rmag >> FRAC_BITS;
        rl = rmag & ((64'd1 << FRAC_BITS) - 1);
        cap = 64'd1 << 40;
        if (rh != 0 && d > cap / rh)
            t = cap;
        else
        begin
            t = rh * d + ((rl * d) >> FRAC_BITS);
            if (t > cap)
                t = cap;
        end
        if (rneg != (dy < 0))
            r = lo - longint'(t);
        else
            r = lo + longint'(t);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // Updates the tables and returns the response a request should produce.
    function automatic rsp_t predict_response(input req_t q);
        rsp_t o;
        int nw, na, wh, ah;
        longint wdx, wdh, adx, adh;
        logic [63:0] wr, ar;
        bit wn, an;
        o = '0;
        case (q.opcode)
            OP_LOAD_WIND:
            begin
                wind_key[q.index] = q.altitude;
                wind_val[0][q.index] = q.value_a;
                wind_val[1][q.index] = q.value_b;
            end
            OP_LOAD_ATMOS:
            begin
                atm_key[q.index] = q.altitude;
                atm_val[0][q.index] = q.value_a;
                atm_val[1][q.index] = q.value_b;
                atm_val[2][q.index] = q.value_c;
                atm_val[3][q.index] = q.value_d;
            end
            OP_QUERY:
            begin
                nw = wind_count_reg > TABLE_DEPTH ? TABLE_DEPTH : wind_count_reg;
                na = atm_count_reg > TABLE_DEPTH ? TABLE_DEPTH : atm_count_reg;
                if (nw < 2 || na < 2)
                    o.status = ST_SHORT;
                else
                begin
                    wh = upper_index(wind_key, nw, q.altitude);
                    ah = upper_index(atm_key, na, q.altitude);
                    wdx = longint'(q.altitude) - wind_key[wh-1];
                    wdh = longint'(wind_key[wh]) - wind_key[wh-1];
                    adx = longint'(q.altitude) - atm_key[ah-1];
                    adh = longint'(atm_key[ah]) - atm_key[ah-1];
                    if (wdh == 0 || adh == 0)
                        o.status = ST_ZERO_SEG;
                    else
                    begin
                        wn = (wdx < 0) != (wdh < 0);
                        an = (adx < 0) != (adh < 0);
                        wr = (magnitude(wdx) << FRAC_BITS) / magnitude(wdh);
                        ar = (magnitude(adx) << FRAC_BITS) / magnitude(adh);
                        o.zonal_wind = blend(wn, wr, wind_val[0][wh-1], wind_val[0][wh]);
                        o.meridional_wind = blend(wn, wr, wind_val[1][wh-1], wind_val[1][wh]);
                        o.pressure = blend(an, ar, atm_val[0][ah-1], atm_val[0][ah]);
                        o.density = blend(an, ar, atm_val[1][ah-1], atm_val[1][ah]);
                        o.temperature = blend(an, ar, atm_val[2][ah-1], atm_val[2][ah]);
                        o.viscosity = blend(an, ar, atm_val[3][ah-1], atm_val[3][ah]);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // Sends one request, idling beforehand at the current rate. Valid stays high
    // after acceptance until the next falling edge, where the next action moves it.
    task automatic send_request(input req_t q);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= q;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(predict_response(q));
    endtask

    task automatic write_count(input logic idx, input int value);
        @(negedge clk);
        req_valid <= 1'b0;
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value[CFG_W-1:0];
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == CFG_WIND_ENTRIES)
            wind_count_reg = value;
        else
            atm_count_reg = value;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(2000) - 1000;
            default: return $urandom();
        endcase
    endfunction

    function automatic req_t load_req(input logic [1:0] op, input int idx,
                                      input logic [31:0] key);
        req_t q;
        q.opcode = op;
        q.index = idx[5:0];
        q.altitude = key;
        q.value_a = rand_word();
        q.value_b = rand_word();
        q.value_c = rand_word();
        q.value_d = rand_word();
        return q;
    endfunction

    function automatic req_t query_req(input logic [31:0] alt);
        req_t q;
        q = load_req(OP_QUERY, $urandom_range(63), alt);
        return q;
    endfunction

    // Loads both tables with n ascending keys (occasionally unsorted or repeated).
    task automatic fill_tables(input int n, input bit messy);
        logic [31:0] key;
        for (int t = 0; t < 2; t++)
        begin
            key = 32'h80000000 + $urandom_range(1 << 20);
            for (int i = 0; i < n; i++)
            begin
                send_request(load_req(t ? OP_LOAD_ATMOS : OP_LOAD_WIND, i, key));
                if (messy && $urandom_range(3) == 0)
                    key = $urandom();
                else
                    key = key + $urandom_range(messy ? 1 : 0, 32'h3ffffff);
            end
        end
    endtask

    function automatic logic [31:0] query_alt();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        return $urandom_range(1) ? $urandom() : (32'h80000000 + $urandom_range(32'h7fffffff));
    endfunction

    // Response side: sample at the rising edge, move ready at the falling edge.
    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        int phase_idle[4] = '{0, 68, 0, 27};
        int phase_stall[4] = '{0, 0, 68, 27};
        int n;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty tables, unused opcode, loads with extreme fields
        send_request(query_req(32'h0));
        send_request(load_req(OP_RESERVED, 63, 32'hffffffff));
        drain();
        write_count(CFG_WIND_ENTRIES, 1);
        write_count(CFG_ATMOS_ENTRIES, 127);
        send_request(load_req(OP_LOAD_WIND, 0, 32'h80000000));
        send_request(query_req(32'h7fffffff));
        drain();
        write_count(CFG_WIND_ENTRIES, 2);
        write_count(CFG_ATMOS_ENTRIES, 2);
        send_request(load_req(OP_LOAD_WIND, 1, 32'h7fffffff));
        send_request(load_req(OP_LOAD_ATMOS, 0, 32'h80000000));
        send_request(load_req(OP_LOAD_ATMOS, 1, 32'h7fffffff));
        send_request(query_req(32'h80000000));
        send_request(query_req(32'h7fffffff));
        send_request(query_req(32'h0));
        // Zero-width segment
        send_request(load_req(OP_LOAD_ATMOS, 1, 32'h80000000));
        send_request(query_req(32'h100));
        drain();

        // Fill every index of both tables so any later count is safe.
        fill_tables(64, 0);
        drain();
        write_count(CFG_WIND_ENTRIES, 64);
        write_count(CFG_ATMOS_ENTRIES, 64);
        send_request(query_req(32'h80000000));
        send_request(query_req(32'h7fffffff));

        // Random phases: mostly small tables, a few at full depth
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int s = 0; s < 5; s++)
            begin
                drain();
                n = (s == 0) ? 64 : $urandom_range(2, 8);
                write_count(CFG_WIND_ENTRIES,
                            $urandom_range(9) == 0 ? $urandom_range(65, 127) : n);
                write_count(CFG_ATMOS_ENTRIES,
                            $urandom_range(9) == 0 ? $urandom_range(1) : n);
                fill_tables(n, $urandom_range(3) == 0);
                for (int k = 0; k < 40; k++)
                    if ($urandom_range(9) == 0)
                        send_request(load_req(2'($urandom_range(1)), $urandom_range(n - 1),
                                              $urandom()));
                    else if ($urandom_range(19) == 0)
                        send_request(load_req(OP_RESERVED, $urandom_range(63), $urandom()));
                    else
                        send_request(query_req(query_alt()));
            end
        end
        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
